// ----- hw/rtl/spr_pkg.sv -----
// ============================================================================
// spr_pkg: shared types and constants for the stream pattern replacer
// Holds the size constants, the payload structs of both channels, the
// configuration bundle and the control bundle that drives each holding cell.
// ============================================================================
package spr_pkg;

	// Longest pattern and replacement that the block supports.
	localparam int MAX_PAT_BYTES = 16;
	localparam int MAX_REP_BYTES = 16;

	// Width of the length fields in the configuration registers.
	localparam int LEN_W = 5;
	// Width of a configuration word and of the register index.
	localparam int CFG_DATA_W = 64;
	localparam int CFG_INDEX_W = 3;

	// Held byte count runs from 0 to MAX_PAT_BYTES.
	localparam int CNT_W = $clog2(MAX_PAT_BYTES + 1);
	// Index of one holding cell.
	localparam int IDX_W = $clog2(MAX_PAT_BYTES);
	// Replacement length and replacement byte index.
	localparam int REP_CNT_W = $clog2(MAX_REP_BYTES + 1);
	localparam int REP_IDX_W = (MAX_REP_BYTES > 1) ? $clog2(MAX_REP_BYTES) : 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_PAT_LOW  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PAT_HIGH = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PAT_LEN  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_REP_LOW  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_REP_HIGH = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_REP_LEN  = 3'd5;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       from_replacement;
		logic       run_last;
		logic       stream_done;
	} out_item_t;

	// Pattern and replacement as seen by the datapath, lengths already clamped.
	typedef struct packed {
		logic [8*MAX_PAT_BYTES-1:0] pattern;
		logic [CNT_W-1:0]           pat_len;
		logic [8*MAX_REP_BYTES-1:0] replacement;
		logic [REP_CNT_W-1:0]       rep_len;
	} cfg_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic load;        // take the incoming stream byte
		logic shift;       // take the neighbor's byte
		logic active;      // cell lies below the held count
		logic active_next; // cell lies below the held count after a shift
	} cell_ctl_t;

endpackage

// ----- hw/rtl/spr_regs.sv -----
// ============================================================================
// spr_regs: configuration registers
// Stores the pattern and replacement words and lengths written through the
// plain write port and presents them with the lengths clamped to range.
// ============================================================================
module spr_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [spr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [spr_pkg::CFG_DATA_W-1:0]     cfg_data,
	output spr_pkg::cfg_t                      cfg
);

	logic [spr_pkg::CFG_DATA_W-1:0] pat_low_q;
	logic [spr_pkg::CFG_DATA_W-1:0] pat_high_q;
	logic [spr_pkg::LEN_W-1:0]      pat_len_q;
	logic [spr_pkg::CFG_DATA_W-1:0] rep_low_q;
	logic [spr_pkg::CFG_DATA_W-1:0] rep_high_q;
	logic [spr_pkg::LEN_W-1:0]      rep_len_q;
	logic [2*spr_pkg::CFG_DATA_W-1:0] pat_full;
	logic [2*spr_pkg::CFG_DATA_W-1:0] rep_full;
	logic [spr_pkg::LEN_W-1:0]      pat_len_clamped;
	logic [spr_pkg::LEN_W-1:0]      rep_len_clamped;

	// A length of zero acts as one, a length above the maximum saturates.
	function automatic logic [spr_pkg::LEN_W-1:0] clamp_len(
		input logic [spr_pkg::LEN_W-1:0] v,
		input logic [spr_pkg::LEN_W-1:0] max_len
	);
		logic [spr_pkg::LEN_W-1:0] r;
		if (v == '0) begin
			r = spr_pkg::LEN_W'(1);
		end else if (v > max_len) begin
			r = max_len;
		end else begin
			r = v;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= spr_pkg::LEN_W'(1);
			rep_low_q  <= '0;
			rep_high_q <= '0;
			rep_len_q  <= spr_pkg::LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				spr_pkg::REG_PAT_LOW:  pat_low_q  <= cfg_data;
				spr_pkg::REG_PAT_HIGH: pat_high_q <= cfg_data;
				spr_pkg::REG_PAT_LEN:  pat_len_q  <= cfg_data[spr_pkg::LEN_W-1:0];
				spr_pkg::REG_REP_LOW:  rep_low_q  <= cfg_data;
				spr_pkg::REG_REP_HIGH: rep_high_q <= cfg_data;
				spr_pkg::REG_REP_LEN:  rep_len_q  <= cfg_data[spr_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pat_full = {pat_high_q, pat_low_q};
		rep_full = {rep_high_q, rep_low_q};
		pat_len_clamped = clamp_len(pat_len_q, spr_pkg::LEN_W'(spr_pkg::MAX_PAT_BYTES));
		rep_len_clamped = clamp_len(rep_len_q, spr_pkg::LEN_W'(spr_pkg::MAX_REP_BYTES));
		cfg.pattern     = pat_full[8*spr_pkg::MAX_PAT_BYTES-1:0];
		cfg.replacement = rep_full[8*spr_pkg::MAX_REP_BYTES-1:0];
		cfg.pat_len     = spr_pkg::CNT_W'(pat_len_clamped);
		cfg.rep_len     = spr_pkg::REP_CNT_W'(rep_len_clamped);
	end

endmodule

// ----- hw/rtl/spr_cell.sv -----
// ============================================================================
// spr_cell: one holding cell of the pattern chain
// Holds one held byte, loads the stream byte or its neighbor's byte, and
// compares both its own and its neighbor's byte with its pattern byte.
// ============================================================================
module spr_cell (
	input  logic               clk,
	input  spr_pkg::cell_ctl_t ctl,
	input  logic [7:0]         load_byte,
	input  logic [7:0]         next_byte,
	input  logic [7:0]         pat_byte,
	output logic [7:0]         held_byte,
	output logic               hit,
	output logic               hit_shift
);

	logic [7:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			data_q <= load_byte;
		end else if (ctl.shift) begin
			data_q <= next_byte;
		end
	end

	// An inactive cell never breaks the prefix match.
	assign held_byte = data_q;
	assign hit       = !ctl.active || (data_q == pat_byte);
	assign hit_shift = !ctl.active_next || (next_byte == pat_byte);

endmodule

// ----- hw/rtl/stream_pattern_replace.sv -----
// ============================================================================
// stream_pattern_replace: streaming search and replace on a byte stream
// Copies an input byte stream to its output and replaces every occurrence
// of a configured pattern by a configured replacement.
// ============================================================================
//
// Usage: each input transfer carries one stream byte and an end_of_stream
// flag. Bytes that may still start the pattern are held in a chain of
// cells; on a mismatch the oldest held byte is released and the rest is
// checked again, on a full match the replacement bytes are sent instead,
// and after an end_of_stream byte the held bytes are flushed unchanged.
// Each output transfer carries one byte; run_last marks the last byte that
// an input transfer caused, and stream_done the final byte of the stream.
// One item is worked on at a time. An item that only extends the held
// prefix is accepted and then checked once against the whole cell chain.
// Every released, flushed or replacement byte is sent in a step of its own;
// the check that finds a full match or the end of the stream is the same
// check that every item gets. The first result of an item is registered
// in the RUN state at the earliest, after the item's accept.
// The output register holds a result while out_stall is high, and the
// sequencer then waits; a new item is taken while the last result waits.
// Reset empties the chain and loads the register reset values.
//
module stream_pattern_replace (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  spr_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output spr_pkg::out_item_t              out_item,
	input  logic                            cfg_we,
	input  logic [spr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [spr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int N = spr_pkg::MAX_PAT_BYTES;

	// IDLE waits for a byte, RUN checks the held prefix and releases bytes,
	// REPL sends the replacement and FLUSH empties the chain at stream end.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_REPL,
		ST_FLUSH
	} state_t;

	state_t                          state_q;
	logic [spr_pkg::CNT_W-1:0]       count_q;
	logic [spr_pkg::REP_IDX_W-1:0]   rep_idx_q;
	logic                            eos_q;
	logic                            out_valid_q;
	spr_pkg::out_item_t              out_item_q;

	spr_pkg::cfg_t                   cfg;
	spr_pkg::cell_ctl_t              cell_ctl [N];
	logic [7:0]                      held [N];
	logic [N-1:0]                    hit_vec;
	logic [N-1:0]                    hit_shift_vec;

	logic                            slot_free;
	logic                            accept;
	logic                            emit;
	logic                            do_shift;
	logic                            prefix;
	logic                            shifted_ok;
	logic                            release_last;
	logic                            rep_last;
	logic [spr_pkg::CNT_W-1:0]       cnt_m1;
	logic [spr_pkg::IDX_W-1:0]       load_idx;
	logic [spr_pkg::CNT_W-1:0]       new_count;
	logic [7:0]                      rep_byte;

	spr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The chain of holding cells. Cell 0 holds the oldest byte; a shift
	// moves every byte one cell toward cell 0.
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [7:0] next_byte;

		if (i < N - 1) begin : g_inner
			assign next_byte = held[i+1];
		end else begin : g_end
			assign next_byte = '0;
		end

		always_comb begin
			cell_ctl[i].load        = accept && (spr_pkg::IDX_W'(i) == load_idx);
			cell_ctl[i].shift       = do_shift;
			cell_ctl[i].active      = spr_pkg::CNT_W'(i) < count_q;
			cell_ctl[i].active_next = spr_pkg::CNT_W'(i + 1) < count_q;
		end

		spr_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[i]),
			.load_byte (in_item.in_byte),
			.next_byte (next_byte),
			.pat_byte  (cfg.pattern[8*i +: 8]),
			.held_byte (held[i]),
			.hit       (hit_vec[i]),
			.hit_shift (hit_shift_vec[i])
		);
	end

	always_comb begin
		// The output register can take a new result this cycle.
		slot_free = !out_valid_q || !out_stall;
		accept    = in_valid && (state_q == ST_IDLE);

		// The held count never passes the last cell before the new byte goes in.
		if (count_q >= spr_pkg::CNT_W'(N)) begin
			load_idx = spr_pkg::IDX_W'(N - 1);
		end else begin
			load_idx = count_q[spr_pkg::IDX_W-1:0];
		end
		new_count = spr_pkg::CNT_W'(load_idx) + spr_pkg::CNT_W'(1);

		// The held bytes are a prefix of the pattern now, and after one
		// release. The second check tells whether a release ends the run.
		prefix     = (count_q <= cfg.pat_len) && (&hit_vec);
		cnt_m1     = count_q - spr_pkg::CNT_W'(1);
		shifted_ok = (cnt_m1 <= cfg.pat_len) && (&hit_shift_vec);

		// A release is the item's last result when the chain runs empty, or
		// when the rest is a partial match that neither completes nor flushes.
		release_last = (cnt_m1 == '0) ||
			(shifted_ok && (cnt_m1 != cfg.pat_len) && !eos_q);

		rep_byte = cfg.replacement[8*rep_idx_q +: 8];
		rep_last = (spr_pkg::REP_CNT_W'(rep_idx_q) + spr_pkg::REP_CNT_W'(1)) == cfg.rep_len;

		// A new result goes into the output register this cycle.
		emit = slot_free &&
			(((state_q == ST_RUN) && !prefix) || (state_q == ST_REPL) ||
			(state_q == ST_FLUSH));

		do_shift = slot_free &&
			(((state_q == ST_RUN) && !prefix) || (state_q == ST_FLUSH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rep_idx_q   <= '0;
			eos_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			// A waiting result leaves once the receiver takes it, and a new
			// one may take its place in the same cycle.
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (slot_free) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= new_count;
						eos_q   <= in_item.end_of_stream;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (slot_free) begin
						if (prefix) begin
							if (count_q == cfg.pat_len) begin
								state_q <= ST_REPL;
							end else if (eos_q && (count_q != '0)) begin
								state_q <= ST_FLUSH;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							// Release the oldest held byte and check again.
							out_item_q.out_byte         <= held[0];
							out_item_q.from_replacement <= 1'b0;
							out_item_q.run_last         <= release_last;
							out_item_q.stream_done      <= release_last && eos_q;
							count_q                     <= cnt_m1;
						end
					end
				end
				ST_REPL: begin
					if (slot_free) begin
						out_item_q.out_byte         <= rep_byte;
						out_item_q.from_replacement <= 1'b1;
						out_item_q.run_last         <= rep_last;
						out_item_q.stream_done      <= rep_last && eos_q;
						if (rep_last) begin
							rep_idx_q <= '0;
							count_q   <= '0;
							state_q   <= ST_IDLE;
						end else begin
							rep_idx_q <= rep_idx_q + spr_pkg::REP_IDX_W'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (slot_free) begin
						out_item_q.out_byte         <= held[0];
						out_item_q.from_replacement <= 1'b0;
						out_item_q.run_last         <= (count_q == spr_pkg::CNT_W'(1));
						out_item_q.stream_done      <= (count_q == spr_pkg::CNT_W'(1));
						count_q                     <= cnt_m1;
						if (count_q == spr_pkg::CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ----- hw/rtl/spr_checker.sv -----
// ============================================================================
// spr_checker: port checks for the stream pattern replacer
// Watches the top level's ports and flags broken transfers or result marks.
// ============================================================================
module spr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input spr_pkg::in_item_t               in_item,
	input logic                            out_valid,
	input logic                            out_stall,
	input spr_pkg::out_item_t              out_item,
	input logic                            cfg_we,
	input logic [spr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [spr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// A stalled result stays offered unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled output transfer changed");

	// The end of the stream is always the last result of its item.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.stream_done |-> out_item.run_last)
		else $error("stream_done without run_last");

	// One item at a time: the input is closed in the cycle after a byte is accepted.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// Nothing is offered in the cycle right after an item is taken
	// while the output register was empty.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result appeared before the item was checked");

endmodule

bind stream_pattern_replace spr_checker u_spr_checker (.*);
